### rtl/ekfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EKF prediction package
// Word format, angle constants, CORDIC arctangent table and the rounding
// and saturation helpers shared by the prediction engine.
// ----------------------------------------------------------------------------
package ekfp_pkg;

    // Word format: signed Q16.16 held in 32 bits.
    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int ACC_W  = 36;

    // Storage layout: pose elements first, then the covariance, row-major.
    localparam int POSE_N    = 6;
    localparam int COV_N     = 36;
    localparam int MEM_DEPTH = POSE_N + COV_N;

    // Pose elements with a role of their own.
    localparam logic [2:0] POSE_PITCH = 3'd3;
    localparam logic [2:0] POSE_YAW   = 3'd4;
    localparam logic [2:0] POSE_SPEED = 3'd5;

    // Function codes of a request.
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_PREDICT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_PITCH_STD = 2'd1;
    localparam logic [1:0] CFG_YAW_STD   = 2'd2;
    localparam logic [1:0] CFG_ACCEL_STD = 2'd3;

    // Angle constants in Q16.16, wide enough for the unwrapped sums.
    localparam logic signed [33:0] TWO_PI  = 34'sd411775;
    localparam logic signed [33:0] PI      = 34'sd205887;
    localparam logic signed [31:0] PI_W    = 32'sd205887;
    localparam logic signed [31:0] HALF_PI = 32'sd102944;

    // CORDIC gain compensation and the unit value of the Jacobian diagonal.
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd39797;
    localparam int                 CORDIC_N    = 17;
    localparam logic signed [31:0] FIX_ONE     = 32'sd65536;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    // Arctangent of 2^-i in Q16.16.
    function automatic logic signed [31:0] atan_val(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd51472;
            5'd1:    v = 32'sd30386;
            5'd2:    v = 32'sd16055;
            5'd3:    v = 32'sd8150;
            5'd4:    v = 32'sd4091;
            5'd5:    v = 32'sd2047;
            5'd6:    v = 32'sd1024;
            5'd7:    v = 32'sd512;
            5'd8:    v = 32'sd256;
            5'd9:    v = 32'sd128;
            5'd10:   v = 32'sd64;
            5'd11:   v = 32'sd32;
            5'd12:   v = 32'sd16;
            5'd13:   v = 32'sd8;
            5'd14:   v = 32'sd4;
            5'd15:   v = 32'sd2;
            5'd16:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp a 64-bit value to the word.
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > WORD_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < WORD_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp an accumulator value to the word.
    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        return sat64(64'(v));
    endfunction

    // Round half up at the binary point, then clamp.
    function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
        return sat64(t);
    endfunction

    // Negate with clamping of the most negative word.
    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh80000000) begin
            r = 32'sh7fffffff;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // Magnitude of a 34-bit signed value.
    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        logic signed [33:0] a;
        a = v[33] ? -v : v;
        return a[32:0];
    endfunction

    // Row times six, used for row-major addressing.
    function automatic logic [5:0] times6(input logic [2:0] r);
        return ({3'b000, r} << 2) + ({3'b000, r} << 1);
    endfunction

endpackage

### rtl/ekf_prediction_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EKF prediction step
// Pose and covariance engine: write or read one element, or run the
// prediction (motion model, angle wrap, J*P*J^T plus process noise) on a
// single shared multiplier around two synchronous memories.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_stall    func, index, value, dt, rates
//  result    out        o_out_valid / i_out_stall  read value, status
//  config    in         i_cfg_valid / o_cfg_ready  register index, data
//
// A write, a rejected predict or an unused code loads the result register on
// acceptance; a read first waits in S_RDW for the memory. A predict is paced
// by the one multiplier, which takes one product a cycle through the 432 terms
// of the two matrix products, after two 17-step CORDIC runs and the angle
// wraps. One request is in work at a time. Reset is synchronous and clears
// all elements to zero through per-entry valid bits. A stalled result holds
// the output register; the block takes no new request until it can deliver.
// ----------------------------------------------------------------------------
module ekf_prediction_step
    import ekfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic [15:0]        i_step_time,
    input  logic signed [31:0] i_gyro_rate_z,
    input  logic signed [31:0] i_gyro_rate_y,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_read_value,
    output logic               o_status,
    // Configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDW, S_LD, S_WRAP, S_WFIX, S_CITER, S_CDONE,
        S_SMUL, S_SWB, S_PRD, S_PWR, S_MAC, S_MDRAIN, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        SS_F0, SS_F1, SS_F2, SS_DV, SS_J04, SS_J05, SS_J14, SS_J15, SS_J23,
        SS_J25, SS_DT2, SS_Q3A, SS_Q3, SS_Q4A, SS_Q4, SS_Q5A, SS_Q5,
        SS_U0, SS_U1, SS_U2, SS_U3, SS_U4, SS_U5
    } t_step;

    // Control and configuration
    t_state              r_st;
    t_step               r_step;
    logic                r_en;
    logic [30:0]         r_pitch_std;
    logic [30:0]         r_yaw_std;
    logic [30:0]         r_accel_std;
    logic                r_out_valid;
    logic signed [31:0]  r_read_value;
    logic                r_status;
    logic [5:0]          r_idx;
    logic                r_rd_ok;
    logic [4:0]          r_cnt;
    logic                r_ang;
    logic                r_wpose;
    logic                r_pass;
    logic [2:0]          r_i;
    logic [2:0]          r_k;
    logic [2:0]          r_j;

    // Predict operands and intermediate values
    logic [15:0]         r_dt;
    logic signed [31:0]  r_gz;
    logic signed [31:0]  r_gy;
    logic signed [31:0]  r_p3;
    logic signed [31:0]  r_p4;
    logic signed [31:0]  r_vel;
    logic signed [31:0]  r_sin_z;
    logic signed [31:0]  r_cos_z;
    logic signed [31:0]  r_sin_y;
    logic signed [31:0]  r_cos_y;
    logic signed [31:0]  r_f0;
    logic signed [31:0]  r_f1;
    logic signed [31:0]  r_f2;
    logic signed [31:0]  r_dv;
    logic signed [31:0]  r_j04;
    logic signed [31:0]  r_j05;
    logic signed [31:0]  r_j14;
    logic signed [31:0]  r_j15;
    logic signed [31:0]  r_j23;
    logic signed [31:0]  r_j25;
    logic signed [31:0]  r_dt2;
    logic signed [31:0]  r_qa;
    logic signed [31:0]  r_q3;
    logic signed [31:0]  r_q4;
    logic signed [31:0]  r_q5;
    logic signed [31:0]  r_u [POSE_N];

    // Angle wrap and CORDIC
    logic                r_wneg;
    logic [32:0]         r_wmag;
    logic signed [31:0]  r_crd_x;
    logic signed [31:0]  r_crd_y;
    logic signed [31:0]  r_crd_a;
    logic                r_cneg;

    // Multiply-accumulate pipeline
    logic signed [63:0]  r_prod;
    logic                r_s1_valid;
    logic                r_s1_last;
    logic                r_s1_first;
    logic [5:0]          r_s1_dest;
    logic signed [31:0]  r_s1_a;
    logic signed [31:0]  r_s1_bias;
    logic                r_s2_valid;
    logic                r_s2_last;
    logic                r_s2_first;
    logic [5:0]          r_s2_dest;
    logic signed [31:0]  r_s2_bias;
    logic signed [ACC_W-1:0] r_acc;

    // Memories
    logic signed [31:0]  r_mem0 [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld0;
    logic signed [31:0]  r_rdata0;
    logic                r_rv0;
    logic signed [31:0]  r_mem1 [COV_N];
    logic signed [31:0]  r_rdata1;

    // Combinational signals
    logic                accept;
    logic                can_load;
    logic                idx_ok;
    logic signed [31:0]  rd0;
    logic [5:0]          raddr0_raw;
    logic [5:0]          raddr0;
    logic [5:0]          raddr1;
    logic                mem0_we;
    logic [5:0]          mem0_waddr;
    logic signed [31:0]  mem0_wdata;
    logic                mem1_we;
    logic signed [31:0]  mres;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [31:0]  sc_a;
    logic signed [31:0]  sc_b;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic [2:0]          jr;
    logic signed [31:0]  jval;
    logic signed [31:0]  bias;
    logic signed [ACC_W-1:0] pose_sum;
    logic signed [33:0]  wrap_cand;
    logic signed [33:0]  wrap_rem;
    logic signed [33:0]  wrap_fix;
    logic signed [31:0]  wrapped;
    logic signed [31:0]  fold_a;
    logic                fold_neg;
    logic [2:0]          u_idx;
    logic signed [31:0]  u_sel;

    // Handshake
    assign can_load     = !r_out_valid || !i_out_stall;
    assign o_in_stall   = !((r_st == S_IDLE) && can_load);
    assign accept       = i_in_valid && !o_in_stall;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign idx_ok       = (i_element_index < 6'(MEM_DEPTH));

    // Elements never written read as zero.
    assign rd0 = r_rv0 ? r_rdata0 : 32'sd0;

    // Product rounding and accumulation.
    assign mres    = rnd_sat(r_prod);
    assign acc_sum = (r_s2_first ? ACC_W'(r_s2_bias) : r_acc) + ACC_W'(mres);

    // Pose update term.
    assign u_idx    = r_i;
    assign u_sel    = r_u[u_idx];
    assign pose_sum = ACC_W'(rd0) + ACC_W'(u_sel);

    // Angle wrap: one restoring step a cycle, then the sign and range fix.
    assign wrap_cand = TWO_PI <<< r_cnt;
    assign wrap_rem  = r_wneg ? -$signed({1'b0, r_wmag}) : $signed({1'b0, r_wmag});
    always_comb begin
        if (wrap_rem <= -PI) begin
            wrap_fix = wrap_rem + TWO_PI;
        end else if (wrap_rem > PI) begin
            wrap_fix = wrap_rem - TWO_PI;
        end else begin
            wrap_fix = wrap_rem;
        end
    end
    assign wrapped = wrap_fix[31:0];

    // Fold the wrapped angle into the CORDIC range.
    always_comb begin
        fold_neg = 1'b1;
        if (wrapped > HALF_PI) begin
            fold_a = wrapped - PI_W;
        end else if (wrapped < -HALF_PI) begin
            fold_a = wrapped + PI_W;
        end else begin
            fold_a   = wrapped;
            fold_neg = 1'b0;
        end
    end

    // Operands of the scalar multiplication sequence.
    always_comb begin
        sc_a = 32'sd0;
        sc_b = 32'sd0;
        case (r_step)
            SS_F0:  begin sc_a = r_vel;               sc_b = r_cos_z; end
            SS_F1:  begin sc_a = r_vel;               sc_b = r_sin_z; end
            SS_F2:  begin sc_a = r_vel;               sc_b = r_sin_y; end
            SS_DV:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_vel;   end
            SS_J04: begin sc_a = r_dv;                sc_b = r_sin_z; end
            SS_J05: begin sc_a = 32'({16'd0, r_dt});  sc_b = r_cos_z; end
            SS_J14: begin sc_a = r_dv;                sc_b = r_cos_z; end
            SS_J15: begin sc_a = 32'({16'd0, r_dt});  sc_b = r_sin_z; end
            SS_J23: begin sc_a = r_dv;                sc_b = r_cos_y; end
            SS_J25: begin sc_a = 32'({16'd0, r_dt});  sc_b = r_sin_y; end
            SS_DT2: begin sc_a = 32'({16'd0, r_dt});  sc_b = 32'({16'd0, r_dt}); end
            SS_Q3A: begin sc_a = r_dt2; sc_b = 32'({1'b0, r_pitch_std}); end
            SS_Q3:  begin sc_a = r_qa;  sc_b = 32'({1'b0, r_pitch_std}); end
            SS_Q4A: begin sc_a = r_dt2; sc_b = 32'({1'b0, r_yaw_std});   end
            SS_Q4:  begin sc_a = r_qa;  sc_b = 32'({1'b0, r_yaw_std});   end
            SS_Q5A: begin sc_a = r_dt2; sc_b = 32'({1'b0, r_accel_std}); end
            SS_Q5:  begin sc_a = r_qa;  sc_b = 32'({1'b0, r_accel_std}); end
            SS_U0:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_f0; end
            SS_U1:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_f1; end
            SS_U2:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_f2; end
            SS_U3:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_gz; end
            SS_U4:  begin sc_a = 32'({16'd0, r_dt});  sc_b = r_gy; end
            default: begin sc_a = 32'sd0; sc_b = 32'sd0; end
        endcase
    end

    // Jacobian entry of the term being issued.
    assign jr = r_pass ? r_k : r_i;
    always_comb begin
        if (jr == r_j) begin
            jval = FIX_ONE;
        end else if (jr == 3'd0 && r_j == 3'd4) begin
            jval = r_j04;
        end else if (jr == 3'd0 && r_j == 3'd5) begin
            jval = r_j05;
        end else if (jr == 3'd1 && r_j == 3'd4) begin
            jval = r_j14;
        end else if (jr == 3'd1 && r_j == 3'd5) begin
            jval = r_j15;
        end else if (jr == 3'd2 && r_j == 3'd3) begin
            jval = r_j23;
        end else if (jr == 3'd2 && r_j == 3'd5) begin
            jval = r_j25;
        end else begin
            jval = 32'sd0;
        end
    end

    // Process noise on the diagonal of the second product.
    always_comb begin
        bias = 32'sd0;
        if (r_pass && r_i == r_k) begin
            if (r_i == POSE_PITCH) begin
                bias = r_q3;
            end else if (r_i == POSE_YAW) begin
                bias = r_q4;
            end else if (r_i == POSE_SPEED) begin
                bias = r_q5;
            end
        end
    end

    // Shared multiplier operands.
    assign mul_a = (r_st == S_SMUL) ? sc_a : r_s1_a;
    assign mul_b = (r_st == S_SMUL) ? sc_b : (r_pass ? r_rdata1 : rd0);

    // Read addresses.
    always_comb begin
        case (r_st)
            S_IDLE:  raddr0_raw = i_element_index;
            S_RDW:   raddr0_raw = r_idx;
            S_LD:    raddr0_raw = 6'(POSE_PITCH) + 6'(r_cnt);
            S_PRD:   raddr0_raw = {3'd0, r_i};
            S_MAC:   raddr0_raw = 6'(POSE_N) + times6(r_j) + {3'd0, r_k};
            default: raddr0_raw = 6'd0;
        endcase
    end
    assign raddr0 = (raddr0_raw < 6'(MEM_DEPTH)) ? raddr0_raw : 6'd0;
    assign raddr1 = times6(r_i) + {3'd0, r_j};

    // Write port of the element memory.
    always_comb begin
        mem0_we    = 1'b0;
        mem0_waddr = 6'd0;
        mem0_wdata = 32'sd0;
        case (r_st)
            S_IDLE: begin
                if (accept && i_func == FUNC_WRITE && idx_ok) begin
                    mem0_we    = 1'b1;
                    mem0_waddr = i_element_index;
                    mem0_wdata = i_element_value;
                end
            end
            S_PWR: begin
                if (r_i != POSE_PITCH && r_i != POSE_YAW) begin
                    mem0_we    = 1'b1;
                    mem0_waddr = {3'd0, r_i};
                    mem0_wdata = sat_acc(pose_sum);
                end
            end
            S_WFIX: begin
                if (r_wpose) begin
                    mem0_we    = 1'b1;
                    mem0_waddr = {3'd0, r_i};
                    mem0_wdata = wrapped;
                end
            end
            S_MAC, S_MDRAIN: begin
                if (r_s2_valid && r_s2_last && r_pass) begin
                    mem0_we    = 1'b1;
                    mem0_waddr = 6'(POSE_N) + r_s2_dest;
                    mem0_wdata = sat_acc(acc_sum);
                end
            end
            default: begin
                mem0_we = 1'b0;
            end
        endcase
    end
    assign mem1_we = r_s2_valid && r_s2_last && !r_pass;

    // Element memory: pose and covariance.
    always_ff @(posedge i_clk) begin
        if (mem0_we) begin
            r_mem0[mem0_waddr] <= mem0_wdata;
        end
        r_rdata0 <= r_mem0[raddr0];
    end

    // Valid bits of the element memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= '0;
            r_rv0  <= 1'b0;
        end else begin
            if (mem0_we) begin
                r_vld0[mem0_waddr] <= 1'b1;
            end
            r_rv0 <= r_vld0[raddr0];
        end
    end

    // Scratch memory for the intermediate product J*P.
    always_ff @(posedge i_clk) begin
        if (mem1_we) begin
            r_mem1[r_s2_dest] <= sat_acc(acc_sum);
        end
        r_rdata1 <= r_mem1[raddr1];
    end

    // Sequencer, datapath registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_step      <= SS_F0;
            r_en        <= 1'b0;
            r_pitch_std <= '0;
            r_yaw_std   <= '0;
            r_accel_std <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ang       <= 1'b0;
            r_wpose     <= 1'b0;
            r_pass      <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:    r_en        <= i_cfg_data[0];
                    CFG_PITCH_STD: r_pitch_std <= i_cfg_data[30:0];
                    CFG_YAW_STD:   r_yaw_std   <= i_cfg_data[30:0];
                    CFG_ACCEL_STD: r_accel_std <= i_cfg_data[30:0];
                    default:       r_en        <= r_en;
                endcase
            end

            // A delivered result frees the output register.
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Multiply-accumulate pipeline.
            r_prod     <= 64'(mul_a) * 64'(mul_b);
            r_s1_valid <= (r_st == S_MAC);
            r_s1_a     <= jval;
            r_s1_last  <= (r_j == 3'd5);
            r_s1_first <= (r_j == 3'd0);
            r_s1_dest  <= times6(r_i) + {3'd0, r_k};
            r_s1_bias  <= bias;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_s2_first <= r_s1_first;
            r_s2_dest  <= r_s1_dest;
            r_s2_bias  <= r_s1_bias;
            if (r_s2_valid && !r_s2_last) begin
                r_acc <= acc_sum;
            end

            unique case (r_st)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= i_element_index;
                        r_dt  <= i_step_time;
                        r_gz  <= i_gyro_rate_z;
                        r_gy  <= i_gyro_rate_y;
                        if (i_func == FUNC_READ) begin
                            r_rd_ok <= idx_ok;
                            r_st    <= S_RDW;
                        end else if (i_func == FUNC_PREDICT && r_en) begin
                            r_cnt <= '0;
                            r_st  <= S_LD;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_read_value <= 32'sd0;
                            r_status     <= (i_func == FUNC_PREDICT);
                        end
                    end
                end
                S_RDW: begin
                    if (can_load) begin
                        r_out_valid  <= 1'b1;
                        r_read_value <= r_rd_ok ? rd0 : 32'sd0;
                        r_status     <= 1'b0;
                        r_st         <= S_IDLE;
                    end
                end
                // Fetch pitch, yaw and speed, then wrap the yaw.
                S_LD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_p3 <= rd0;
                    end
                    if (r_cnt == 5'd2) begin
                        r_p4 <= rd0;
                    end
                    if (r_cnt == 5'd3) begin
                        r_vel   <= rd0;
                        r_ang   <= 1'b0;
                        r_wpose <= 1'b0;
                        r_wneg  <= r_p4[31];
                        r_wmag  <= mag34(34'(r_p4));
                        r_cnt   <= 5'd14;
                        r_st    <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if ($signed({1'b0, r_wmag}) >= wrap_cand) begin
                        r_wmag <= 33'(34'($signed({1'b0, r_wmag}) - wrap_cand));
                    end
                    if (r_cnt == 5'd0) begin
                        r_st <= S_WFIX;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                // Wrapped angle goes back to the pose or into the CORDIC.
                S_WFIX: begin
                    if (r_wpose) begin
                        if (r_i == POSE_SPEED) begin
                            r_st <= S_MAC;
                        end else begin
                            r_i  <= r_i + 3'd1;
                            r_st <= S_PRD;
                        end
                    end else begin
                        r_crd_a <= fold_a;
                        r_cneg  <= fold_neg;
                        r_crd_x <= CORDIC_GAIN;
                        r_crd_y <= 32'sd0;
                        r_cnt   <= '0;
                        r_st    <= S_CITER;
                    end
                end
                S_CITER: begin
                    if (r_crd_a >= 32'sd0) begin
                        r_crd_x <= r_crd_x - (r_crd_y >>> r_cnt);
                        r_crd_y <= r_crd_y + (r_crd_x >>> r_cnt);
                        r_crd_a <= r_crd_a - atan_val(r_cnt);
                    end else begin
                        r_crd_x <= r_crd_x + (r_crd_y >>> r_cnt);
                        r_crd_y <= r_crd_y - (r_crd_x >>> r_cnt);
                        r_crd_a <= r_crd_a + atan_val(r_cnt);
                    end
                    if (r_cnt == 5'(CORDIC_N - 1)) begin
                        r_st <= S_CDONE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CDONE: begin
                    if (!r_ang) begin
                        r_sin_z <= r_cneg ? -r_crd_y : r_crd_y;
                        r_cos_z <= r_cneg ? -r_crd_x : r_crd_x;
                        r_ang   <= 1'b1;
                        r_wneg  <= r_p3[31];
                        r_wmag  <= mag34(34'(r_p3));
                        r_cnt   <= 5'd14;
                        r_st    <= S_WRAP;
                    end else begin
                        r_sin_y <= r_cneg ? -r_crd_y : r_crd_y;
                        r_cos_y <= r_cneg ? -r_crd_x : r_crd_x;
                        r_step  <= SS_F0;
                        r_st    <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    r_st <= S_SWB;
                end
                // Store the rounded product of the scalar step.
                S_SWB: begin
                    case (r_step)
                        SS_F0:  r_f0  <= mres;
                        SS_F1:  r_f1  <= mres;
                        SS_F2:  r_f2  <= mres;
                        SS_DV:  r_dv  <= mres;
                        SS_J04: r_j04 <= neg_sat(mres);
                        SS_J05: r_j05 <= mres;
                        SS_J14: r_j14 <= mres;
                        SS_J15: r_j15 <= mres;
                        SS_J23: r_j23 <= mres;
                        SS_J25: r_j25 <= mres;
                        SS_DT2: r_dt2 <= mres;
                        SS_Q3:  r_q3  <= mres;
                        SS_Q4:  r_q4  <= mres;
                        SS_Q5:  r_q5  <= mres;
                        SS_U0:  r_u[0] <= mres;
                        SS_U1:  r_u[1] <= mres;
                        SS_U2:  r_u[2] <= mres;
                        SS_U3:  r_u[3] <= mres;
                        SS_U4:  r_u[4] <= mres;
                        SS_U5:  r_u[5] <= mres;
                        default: r_qa <= mres;
                    endcase
                    if (r_step == SS_U5) begin
                        r_i  <= '0;
                        r_st <= S_PRD;
                    end else begin
                        r_step <= t_step'(r_step + 5'd1);
                        r_st   <= S_SMUL;
                    end
                end
                S_PRD: begin
                    r_st <= S_PWR;
                end
                // Pose update; the angles take a trip through the wrap.
                S_PWR: begin
                    if (r_i == POSE_PITCH || r_i == POSE_YAW) begin
                        r_wpose <= 1'b1;
                        r_wneg  <= pose_sum[ACC_W-1];
                        r_wmag  <= mag34(34'(pose_sum));
                        r_cnt   <= 5'd14;
                        r_st    <= S_WRAP;
                    end else if (r_i == POSE_SPEED) begin
                        r_i    <= '0;
                        r_k    <= '0;
                        r_j    <= '0;
                        r_pass <= 1'b0;
                        r_st   <= S_MAC;
                    end else begin
                        r_i  <= r_i + 3'd1;
                        r_st <= S_PRD;
                    end
                end
                // Issue one product term a cycle over row, column and sum.
                S_MAC: begin
                    if (r_j == 3'd5) begin
                        r_j <= '0;
                        if (r_k == 3'd5) begin
                            r_k <= '0;
                            if (r_i == 3'd5) begin
                                r_i   <= '0;
                                r_cnt <= '0;
                                r_st  <= S_MDRAIN;
                            end else begin
                                r_i <= r_i + 3'd1;
                            end
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                S_MDRAIN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        if (r_pass) begin
                            r_st <= S_FIN;
                        end else begin
                            r_pass <= 1'b1;
                            r_st   <= S_MAC;
                        end
                    end
                end
                S_FIN: begin
                    if (can_load) begin
                        r_out_valid  <= 1'b1;
                        r_read_value <= 32'sd0;
                        r_status     <= 1'b0;
                        r_pass       <= 1'b0;
                        r_st         <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    // The request side is closed while a request is in work.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_in_stall)
        else $error("request taken while busy");

    // A waiting result is neither lost nor changed.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_read_value)))
        else $error("waiting result overwritten");

    // Matrix terms only travel the pipeline during the matrix passes.
    a_mac_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_st == S_MAC || r_st == S_MDRAIN))
        else $error("product term outside matrix pass");

    // The CORDIC never runs past its table.
    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CITER) |-> (r_cnt < 5'(CORDIC_N)))
        else $error("CORDIC step out of range");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EKF prediction step testbench
// Drives write, read, predict and unused-code requests with random gaps on both channels.
// A scoreboard keeps a shadow copy of the pose and the covariance, computes
// each expected result and checks every result against it in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ekfp_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic [5:0]         index;
        logic signed [31:0] value;
        logic [15:0]        dt;
        logic signed [31:0] rate_z;
        logic signed [31:0] rate_y;
    } ekf_request_t;

    typedef struct {
        logic signed [31:0] read_value;
        logic               status;
    } ekf_result_t;

    // Shadow of the pose and covariance that predicts each result.
    class pose_cov_scoreboard;
        longint      pose[6];
        longint      cov[36];
        bit          enabled;
        longint      pitch_std, yaw_std, accel_std;
        ekf_result_t pending_results[$];
        int          errors;

        function new();
            foreach (pose[i]) pose[i] = 0;
            foreach (cov[i]) cov[i] = 0;
            enabled = 0;
            pitch_std = 0;
            yaw_std = 0;
            accel_std = 0;
            errors = 0;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Exact product, rounded half up at the binary point, then clamped.
        function longint qmul(longint a, longint b);
            return clamp((a * b + 64'sd32768) >>> 16);
        endfunction

        // Truncated remainder by 2pi, then one correction into (-pi, pi].
        function longint wrap_angle(longint v);
            longint r;
            r = v % 64'sd411775;
            if (r <= -64'sd205887) r += 64'sd411775;
            else if (r > 64'sd205887) r -= 64'sd411775;
            return r;
        endfunction

        // Rotation-mode CORDIC with a half-turn fold outside +-pi/2.
        function void sin_cos(longint angle, output longint s, output longint c);
            longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2, 1};
            longint a, x, y, nx;
            bit     flip;
            a = wrap_angle(angle);
            x = 39797;
            y = 0;
            flip = 0;
            if (a > 64'sd102944) begin
                a -= 64'sd205887;
                flip = 1;
            end else if (a < -64'sd102944) begin
                a += 64'sd205887;
                flip = 1;
            end
            for (int i = 0; i < 17; i++) begin
                if (a >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    a -= atan_tab[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    a += atan_tab[i];
                end
                x = nx;
            end
            s = clamp(flip ? -y : y);
            c = clamp(flip ? -x : x);
        endfunction

        function void run_predict(longint dt, longint gz, longint gy);
            longint jac[6][6], tmp[6][6], noise[6], drift[6];
            longint vel, sz, cz, sy, cy, dv, dt2, acc;
            vel = pose[5];
            sin_cos(pose[4], sz, cz);
            sin_cos(pose[3], sy, cy);
            drift = '{qmul(vel, cz), qmul(vel, sz), qmul(vel, sy), gz, gy, 0};
            foreach (jac[i, j]) jac[i][j] = (i == j) ? 64'sd65536 : 0;
            dv = qmul(dt, vel);
            jac[0][4] = clamp(-qmul(dv, sz));
            jac[0][5] = qmul(dt, cz);
            jac[1][4] = qmul(dv, cz);
            jac[1][5] = qmul(dt, sz);
            jac[2][3] = qmul(dv, cy);
            jac[2][5] = qmul(dt, sy);
            dt2 = qmul(dt, dt);
            noise = '{0, 0, 0, qmul(qmul(dt2, pitch_std), pitch_std),
                      qmul(qmul(dt2, yaw_std), yaw_std),
                      qmul(qmul(dt2, accel_std), accel_std)};
            // Angles wrap on the exact sum; the rest saturate.
            for (int i = 0; i < 6; i++) begin
                acc = pose[i] + qmul(dt, drift[i]);
                pose[i] = (i == 3 || i == 4) ? wrap_angle(acc) : clamp(acc);
            end
            for (int i = 0; i < 6; i++) begin
                for (int k = 0; k < 6; k++) begin
                    acc = 0;
                    for (int j = 0; j < 6; j++) acc += qmul(jac[i][j], cov[j * 6 + k]);
                    tmp[i][k] = clamp(acc);
                end
            end
            for (int i = 0; i < 6; i++) begin
                for (int k = 0; k < 6; k++) begin
                    acc = (i == k) ? noise[i] : 0;
                    for (int j = 0; j < 6; j++) acc += qmul(tmp[i][j], jac[k][j]);
                    cov[i * 6 + k] = clamp(acc);
                end
            end
        endfunction

        function void set_register(logic [1:0] index, logic [31:0] data);
            case (index)
                CFG_ENABLE:    enabled = data[0];
                CFG_PITCH_STD: pitch_std = longint'(data[30:0]);
                CFG_YAW_STD:   yaw_std = longint'(data[30:0]);
                CFG_ACCEL_STD: accel_std = longint'(data[30:0]);
                default: ;
            endcase
        endfunction

        function void note_request(ekf_request_t r);
            ekf_result_t res;
            res.read_value = 0;
            res.status = 0;
            case (r.func)
                FUNC_WRITE: begin
                    if (r.index < 6) pose[r.index] = longint'(r.value);
                    else if (r.index < 42) cov[r.index - 6] = longint'(r.value);
                end
                FUNC_READ: begin
                    if (r.index < 6) res.read_value = pose[r.index];
                    else if (r.index < 42) res.read_value = cov[r.index - 6];
                end
                FUNC_PREDICT: begin
                    if (enabled) begin
                        run_predict(longint'(r.dt), longint'(r.rate_z), longint'(r.rate_y));
                    end else begin
                        res.status = 1;
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] read_value, logic status);
            ekf_result_t e;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: read_value %0d status %0d",
                       read_value, status);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (read_value !== e.read_value) begin
                $error("read_value: expected %0d, actual %0d", e.read_value, read_value);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = FUNC_WRITE;
    logic [5:0]         i_element_index = '0;
    logic signed [31:0] i_element_value = '0;
    logic [15:0]        i_step_time = '0;
    logic signed [31:0] i_gyro_rate_z = '0;
    logic signed [31:0] i_gyro_rate_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_read_value;
    logic               o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_ENABLE;
    logic [31:0]        i_cfg_data = '0;

    pose_cov_scoreboard sb = new();
    bit                 quiet = 0;
    int                 stall_left = 0;
    int                 idle_cycles = 0;

    ekf_prediction_step uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver stalls in random bursts until the quiet part of the run.
    always @(negedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 9);
        end
        if (!quiet && stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check every result that is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_read_value, o_status);
        end
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= 20000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_request(input ekf_request_t r);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func <= r.func;
        i_element_index <= r.index;
        i_element_value <= r.value;
        i_step_time <= r.dt;
        i_gyro_rate_z <= r.rate_z;
        i_gyro_rate_y <= r.rate_y;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(r);
    endtask

    task automatic request(input logic [1:0] func, input logic [5:0] index,
                           input logic signed [31:0] value, input logic [15:0] dt,
                           input logic signed [31:0] rate_z,
                           input logic signed [31:0] rate_y);
        ekf_request_t r;
        r = '{func, index, value, dt, rate_z, rate_y};
        send_request(r);
    endtask

    // Let the block drain before a register write.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index <= index;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input bit en, input logic [31:0] p, input logic [31:0] y,
                             input logic [31:0] a);
        write_register(CFG_ENABLE, {$urandom() >> 1, en});
        write_register(CFG_PITCH_STD, p);
        write_register(CFG_YAW_STD, y);
        write_register(CFG_ACCEL_STD, a);
    endtask

    // Mix of full-range, extreme and moderate Q16.16 values.
    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic [31:0] pick_std(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1 << 17);
            2: return 32'h7fffffff | ($urandom() & 32'h80000000);
            3: return 32'h0;
            default: return $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 18);
        endcase
    endfunction

    task automatic random_request();
        ekf_request_t r;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) r.func = FUNC_WRITE;
        else if (pick < 62) r.func = FUNC_READ;
        else if (pick < 95) r.func = FUNC_PREDICT;
        else r.func = 2'd3;
        r.index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(42, 63))
                                              : 6'($urandom_range(0, 41));
        r.value = pick_q16();
        r.dt = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 2000));
        r.rate_z = pick_q16();
        r.rate_y = pick_q16();
        send_request(r);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, extremes, bad indexes, disabled predict.
        request(FUNC_READ, 6'd0, 0, 0, 0, 0);
        request(FUNC_READ, 6'd41, 0, 0, 0, 0);
        request(FUNC_PREDICT, 6'd0, 0, 16'hffff, 32'sh7fffffff, 32'sh80000000);
        request(FUNC_WRITE, 6'd0, 32'sh7fffffff, 0, 0, 0);
        request(FUNC_WRITE, 6'd1, 32'sh80000000, 0, 0, 0);
        request(FUNC_WRITE, 6'd41, -32'sd1, 0, 0, 0);
        request(FUNC_WRITE, 6'd42, 32'sh12345678, 0, 0, 0);
        request(FUNC_WRITE, 6'd63, -32'sd5, 0, 0, 0);
        request(FUNC_READ, 6'd0, 0, 0, 0, 0);
        request(FUNC_READ, 6'd1, 0, 0, 0, 0);
        request(FUNC_READ, 6'd41, 0, 0, 0, 0);
        request(FUNC_READ, 6'd42, 0, 0, 0, 0);
        request(FUNC_READ, 6'd63, 0, 0, 0, 0);
        request(2'd3, 6'd5, 32'sh7fffffff, 16'hffff, -1, -1);
        wait_drained();

        // Directed predicts around the half-turn and with extreme rates.
        configure(1'b1, 32'h10000, 32'h8000, 32'h7fffffff);
        request(FUNC_WRITE, 6'd3, 32'sd205887, 0, 0, 0);
        request(FUNC_WRITE, 6'd4, -32'sd205887, 0, 0, 0);
        request(FUNC_WRITE, 6'd5, 32'sd131072, 0, 0, 0);
        request(FUNC_WRITE, 6'd6, 32'sd65536, 0, 0, 0);
        request(FUNC_WRITE, 6'd34, 32'sd65536, 0, 0, 0);
        request(FUNC_PREDICT, 6'd0, 0, 16'hffff, 32'sh7fffffff, 32'sh80000000);
        request(FUNC_PREDICT, 6'd0, 0, 16'h0000, 32'sd102944, -32'sd102944);
        request(FUNC_READ, 6'd3, 0, 0, 0, 0);
        request(FUNC_READ, 6'd4, 0, 0, 0, 0);
        request(FUNC_READ, 6'd6, 0, 0, 0, 0);

        // Random phases, each loading the full state first.
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            if (phase == 4) quiet = 1;
            configure(phase != 0, pick_std(phase), pick_std(phase), pick_std(phase));
            for (int i = 0; i < 42; i++) request(FUNC_WRITE, 6'(i), pick_q16(), 0, 0, 0);
            repeat (125) random_request();
        end
        wait_drained();

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/ekfp_pkg.sv
rtl/ekf_prediction_step.sv
bench/tb_top.sv
